// ===== rtl/rbch_pkg.sv =====
// Shared types and constants of the ray box closest hit core.
package rbch_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = 33;
   localparam int MAG_W     = 33;
   localparam int INV_W     = 40;
   localparam int HALF_W    = 20;
   localparam int PROD_W    = MAG_W + HALF_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int PSAT_W    = 41;
   localparam int T_W       = 42;
   localparam int LANES     = 3;
   localparam int DIV_STEPS = 50;
   localparam int CNT_W     = 6;
   localparam int ACTOR_W   = 10;
   localparam int DIST_W    = 31;

   localparam logic [COORD_W-1:0] PAR_LIMIT = 32'd1074;
   localparam logic [COORD_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
   localparam logic [SUM_W-1:0]   T_SAT     = {14'b0, 1'b1, 40'b0};

   typedef enum logic {
      OP_RAY = 1'b0,
      OP_BOX = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [T_W-1:0] t_near;
      logic signed [T_W-1:0] t_far;
      logic                  par_fail;
   } slab_res_type;

endpackage

// ===== rtl/ray_box_closest_hit_core.sv =====
// Ray box closest hit core: ray setup, three slab lanes and the hit record.
// Ray item: the next item is accepted only after the 50-step reciprocal dividers finish.
// Eligible box item: six slab lane stages plus two merge stages and the record update.
// Ineligible box item: the core stays idle; a last box goes to the emit state to load the result.
// Reset: synchronous; clears the record, origin and reciprocals, marks every axis parallel.
module ray_box_closest_hit_core
   import rbch_pkg::*;
#(
   parameter int MAX_ACTORS = 1024
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // actor_index, a_x, a_y, a_z, b_x, b_y, b_z, max_distance, zero fill
   input  logic [239:0] req_tdata,
   // operation, eligible
   input  logic [1:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_actor, hit_distance, zero fill
   output logic [47:0]  rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RAYDIV,
      ST_BOX,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic signed [COORD_W-1:0] org_ff [LANES];
   logic [INV_W-1:0]          inv_mag_ff [LANES];
   logic [LANES-1:0]          inv_neg_ff;
   logic [LANES-1:0]          par_ff;
   logic [COORD_W-1:0]        closest_ff;
   logic [ACTOR_W-1:0]        actor_ff;
   logic                      found_ff;
   logic [ACTOR_W-1:0]        box_actor_ff;
   logic                      box_last_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [ACTOR_W-1:0]        rsp_actor_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   logic                      accept;
   logic                      is_ray;
   logic [ACTOR_W-1:0]        in_actor;
   logic signed [COORD_W-1:0] in_a [LANES];
   logic signed [COORD_W-1:0] in_b [LANES];
   logic signed [COORD_W-1:0] in_max;
   logic [COORD_W-1:0]        in_mag [LANES];
   logic                      box_ok;
   logic                      div_start, slab_start;
   logic [LANES-1:0]          div_done, slab_done;
   logic [INV_W-1:0]          quo [LANES];
   slab_res_type              slab_res [LANES];
   logic                      merge_done, merge_hit;
   logic [COORD_W-1:0]        merge_dist;
   logic                      slot_free;

   always_comb begin
      accept   = req_tvalid && req_tready;
      is_ray   = (op_type'(req_tuser[0]) == OP_RAY);
      in_actor = req_tdata[9:0];
      for (int i = 0; i < LANES; i++) begin
         in_a[i]   = req_tdata[10 + 32*i +: 32];
         in_b[i]   = req_tdata[106 + 32*i +: 32];
         in_mag[i] = in_b[i][COORD_W-1] ? COORD_W'(-in_b[i]) : COORD_W'(in_b[i]);
      end
      in_max     = req_tdata[233:202];
      box_ok     = req_tuser[1] && ({22'b0, in_actor} < 32'(MAX_ACTORS));
      div_start  = accept && is_ray;
      slab_start = accept && !is_ray && box_ok;
      slot_free  = !rsp_valid_ff || rsp_tready;
   end

   assign req_tready = (state_ff == ST_IDLE);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rbch_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .divisor  (in_mag[g]),
         .done     (div_done[g]),
         .quotient (quo[g])
      );

      rbch_slab u_slab (
         .clock   (clock),
         .reset   (reset),
         .start   (slab_start),
         .org     (org_ff[g]),
         .lo      (in_a[g]),
         .hi      (in_b[g]),
         .inv_mag (inv_mag_ff[g]),
         .inv_neg (inv_neg_ff[g]),
         .par     (par_ff[g]),
         .done    (slab_done[g]),
         .res     (slab_res[g])
      );
   end

   rbch_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .start    (slab_done[0]),
      .res      (slab_res),
      .par      (par_ff),
      .closest  (closest_ff),
      .done     (merge_done),
      .hit      (merge_hit),
      .hit_dist (merge_dist)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < LANES; i++) begin
            org_ff[i]     <= '0;
            inv_mag_ff[i] <= '0;
         end
         inv_neg_ff   <= '0;
         par_ff       <= '1;
         closest_ff   <= DIST_MAX;
         actor_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_ray) begin
                     for (int i = 0; i < LANES; i++) begin
                        org_ff[i]     <= in_a[i];
                        inv_neg_ff[i] <= in_b[i][COORD_W-1];
                        par_ff[i]     <= (in_mag[i] < PAR_LIMIT);
                     end
                     closest_ff <= in_max[COORD_W-1] ? DIST_MAX : in_max;
                     actor_ff   <= '0;
                     found_ff   <= 1'b0;
                     state_ff   <= ST_RAYDIV;
                  end else begin
                     box_actor_ff <= in_actor;
                     box_last_ff  <= req_tlast;
                     if (box_ok) state_ff <= ST_BOX;
                     else if (req_tlast) state_ff <= ST_EMIT;
                  end
               end
            end
            ST_RAYDIV: begin
               if (div_done[0]) begin
                  for (int i = 0; i < LANES; i++)
                     inv_mag_ff[i] <= par_ff[i] ? '0 : quo[i];
                  state_ff <= ST_IDLE;
               end
            end
            ST_BOX: begin
               if (merge_done) begin
                  if (merge_hit) begin
                     closest_ff <= merge_dist;
                     actor_ff   <= box_actor_ff;
                     found_ff   <= 1'b1;
                  end
                  state_ff <= box_last_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (slot_free) begin
                  rsp_hit_ff   <= found_ff;
                  rsp_actor_ff <= found_ff ? actor_ff : '0;
                  rsp_dist_ff  <= found_ff ? closest_ff[DIST_W-1:0] : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if ((state_ff == ST_EMIT) && slot_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_dist_ff, rsp_actor_ff};
   assign rsp_tuser  = rsp_hit_ff;

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss result carries nonzero payload");

   a_closest_range: assert property (@(posedge clock) disable iff (reset)
      !closest_ff[COORD_W-1])
      else $error("closest distance out of range");

   a_merge_in_box: assert property (@(posedge clock) disable iff (reset)
      merge_done |-> state_ff == ST_BOX)
      else $error("merge result outside box test");

   a_ray_clears: assert property (@(posedge clock) disable iff (reset)
      accept && is_ray |=> !found_ff && actor_ff == '0)
      else $error("ray item did not clear the record");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      ((&div_done) || !(|div_done)) && ((&slab_done) || !(|slab_done)))
      else $error("lanes finished out of step");

endmodule

// ===== rtl/rbch_div.sv =====
// Restoring divider lane: reciprocal 2^49 / divisor, one quotient bit per cycle.
module rbch_div
   import rbch_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] divisor,
   output logic               done,
   output logic [INV_W-1:0]   quotient
);

   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [COORD_W-1:0] rem_ff;
   logic [COORD_W-1:0] div_ff;
   logic [INV_W-1:0]   quo_ff;

   logic               bit_in;
   logic [COORD_W:0]   trial;
   logic [COORD_W:0]   sub;
   logic               ge;

   always_comb begin
      bit_in = (cnt_ff == CNT_W'(DIV_STEPS - 1));
      trial  = {rem_ff, bit_in};
      ge     = (trial >= {1'b0, div_ff});
      sub    = trial - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == '0);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_STEPS - 1);
            rem_ff <= '0;
            quo_ff <= '0;
            div_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= ge ? sub[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_ff <= {quo_ff[INV_W-2:0], ge};
            if (cnt_ff == '0) begin
               run_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/rbch_slab.sv =====
// Slab lane: entry and exit distances of one axis over six pipeline stages.
module rbch_slab
   import rbch_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] org,
   input  logic signed [COORD_W-1:0] lo,
   input  logic signed [COORD_W-1:0] hi,
   input  logic [INV_W-1:0]          inv_mag,
   input  logic                      inv_neg,
   input  logic                      par,
   output logic                      done,
   output slab_res_type              res
);

   logic [5:0]               vld_ff;
   logic signed [DIFF_W-1:0] d0_ff, d1_ff;
   logic [MAG_W-1:0]         a0_ff, a1_ff;
   logic [PROD_W-1:0]        ph0_ff, pl0_ff, ph1_ff, pl1_ff;
   logic [PSAT_W-1:0]        p0_ff, p1_ff;
   logic signed [T_W-1:0]    t0_ff, t1_ff;
   logic [4:2]               n0_ff, n1_ff;
   logic [5:1]               pf_ff;
   slab_res_type             res_ff;

   logic [SUM_W-1:0]         s0, s1;

   always_comb begin
      s0 = {1'b0, ph0_ff, 1'b0} + SUM_W'(pl0_ff >> 19);
      s1 = {1'b0, ph1_ff, 1'b0} + SUM_W'(pl1_ff >> 19);
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[4:0], start};
      if (start) begin
         d0_ff    <= DIFF_W'(lo) - DIFF_W'(org);
         d1_ff    <= DIFF_W'(hi) - DIFF_W'(org);
         pf_ff[1] <= par && ((org < lo) || (org > hi));
      end
      // stage 2: magnitude and product sign
      a0_ff    <= d0_ff[DIFF_W-1] ? MAG_W'(-d0_ff) : MAG_W'(d0_ff);
      a1_ff    <= d1_ff[DIFF_W-1] ? MAG_W'(-d1_ff) : MAG_W'(d1_ff);
      n0_ff[2] <= d0_ff[DIFF_W-1] ^ inv_neg;
      n1_ff[2] <= d1_ff[DIFF_W-1] ^ inv_neg;
      pf_ff[2] <= pf_ff[1];
      // stage 3: split products
      ph0_ff   <= a0_ff * inv_mag[INV_W-1:HALF_W];
      pl0_ff   <= a0_ff * inv_mag[HALF_W-1:0];
      ph1_ff   <= a1_ff * inv_mag[INV_W-1:HALF_W];
      pl1_ff   <= a1_ff * inv_mag[HALF_W-1:0];
      n0_ff[3] <= n0_ff[2];
      n1_ff[3] <= n1_ff[2];
      pf_ff[3] <= pf_ff[2];
      // stage 4: sum and saturate
      p0_ff    <= (s0 > T_SAT) ? T_SAT[PSAT_W-1:0] : s0[PSAT_W-1:0];
      p1_ff    <= (s1 > T_SAT) ? T_SAT[PSAT_W-1:0] : s1[PSAT_W-1:0];
      n0_ff[4] <= n0_ff[3];
      n1_ff[4] <= n1_ff[3];
      pf_ff[4] <= pf_ff[3];
      // stage 5: apply sign
      t0_ff    <= n0_ff[4] ? -$signed({1'b0, p0_ff}) : $signed({1'b0, p0_ff});
      t1_ff    <= n1_ff[4] ? -$signed({1'b0, p1_ff}) : $signed({1'b0, p1_ff});
      pf_ff[5] <= pf_ff[4];
      // stage 6: order the slab ends
      res_ff.t_near   <= (t0_ff > t1_ff) ? t1_ff : t0_ff;
      res_ff.t_far    <= (t0_ff > t1_ff) ? t0_ff : t1_ff;
      res_ff.par_fail <= pf_ff[5];
   end

   assign done = vld_ff[5];
   assign res  = res_ff;

endmodule

// ===== rtl/rbch_merge.sv =====
// Merge stage: combines the three lane intervals and decides a nearer hit.
module rbch_merge
   import rbch_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  slab_res_type       res [LANES],
   input  logic [LANES-1:0]   par,
   input  logic [COORD_W-1:0] closest,
   output logic               done,
   output logic               hit,
   output logic [COORD_W-1:0] hit_dist
);

   logic                  v1_ff, v2_ff;
   logic signed [T_W-1:0] tlo_ff, thi_ff;
   logic                  fail_ff;
   logic                  hit_ff;
   logic [COORD_W-1:0]    dist_ff;

   logic signed [T_W-1:0] tlo, thi, lim;
   logic                  fail;

   always_comb begin
      lim  = $signed({10'b0, closest});
      tlo  = '0;
      thi  = lim;
      fail = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         fail = fail | res[i].par_fail;
         if (!par[i]) begin
            if (res[i].t_near > tlo) tlo = res[i].t_near;
            if (res[i].t_far < thi) thi = res[i].t_far;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      tlo_ff  <= tlo;
      thi_ff  <= thi;
      fail_ff <= fail;
      hit_ff  <= !fail_ff && !(thi_ff < tlo_ff) && (tlo_ff < lim);
      dist_ff <= tlo_ff[COORD_W-1:0];
   end

   assign done     = v2_ff;
   assign hit      = hit_ff;
   assign hit_dist = dist_ff;

endmodule
